// ----- rtl/bha_pkg.sv -----
// ----------------------------------------------------------------------------
// bha_pkg
// shared widths, request codes and parameter defaults of the block heap
// allocator
// ----------------------------------------------------------------------------
package bha_pkg;

   localparam int NUM_BLOCKS_DEFAULT  = 128;
   localparam int BLOCK_BYTES_DEFAULT = 8;

   localparam int BYTES_W  = 16;
   localparam int OFFSET_W = 10;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_code_type;

endpackage

// ----- rtl/bha_ram.sv -----
// ----------------------------------------------------------------------------
// bha_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/block_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// block_heap_allocator_core
// first-fit allocator of contiguous block runs over a fixed heap, with the
// per-block used mark and owner start index held in one ram
// ----------------------------------------------------------------------------
//  channel   ports                                          transfer
//  request   start, busy, req_type, req_alloc_bytes,        start & !busy
//            req_free_offset, req_free_is_null
//  response  rsp_valid, rsp_alloc_ok, rsp_alloc_offset      rsp_valid, one cycle
//
//  allocate: the scan reads the ram one entry per cycle, stopping at the end
//  of the first run that fits, then marks each block of the found run; free:
//  the scan reads every entry; zero size and null free answer in the cycle
//  after the request is taken, with no scan. the single ram port pair sets
//  this pace. after reset a clearing pass writes every entry with busy high.
//  the receiver cannot stall: each response is a one cycle strobe.
// ----------------------------------------------------------------------------
module block_heap_allocator_core #(
   parameter int NUM_BLOCKS  = bha_pkg::NUM_BLOCKS_DEFAULT,
   parameter int BLOCK_BYTES = bha_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [bha_pkg::BYTES_W-1:0]  req_alloc_bytes,
   input  logic [bha_pkg::OFFSET_W-1:0] req_free_offset,
   input  logic                         req_free_is_null,
   output logic                         rsp_valid,
   output logic                         rsp_alloc_ok,
   output logic [bha_pkg::OFFSET_W-1:0] rsp_alloc_offset
);

   localparam int IDX_W   = $clog2(NUM_BLOCKS);
   localparam int ENTRY_W = IDX_W + 1;
   localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
   localparam int PROD_W  = IDX_W + BB_W;
   localparam int CMP_W   = (PROD_W > bha_pkg::OFFSET_W) ? PROD_W : bha_pkg::OFFSET_W;
   localparam int RUNB_W0 = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
   localparam int RB_W    = (RUNB_W0 > bha_pkg::BYTES_W) ? RUNB_W0 : bha_pkg::BYTES_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FREE  = 5'b00100,
      ST_ALLOC = 5'b01000,
      ST_MARK  = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         issue_ff, issue_in;
   logic                         pend_ff, pend_in;
   logic [IDX_W-1:0]             pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]             run_ff, run_in;
   logic [RB_W-1:0]              runb_ff, runb_in;
   logic [IDX_W-1:0]             first_ff, first_in;
   logic [IDX_W-1:0]             mark_end_ff, mark_end_in;
   logic [bha_pkg::BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [bha_pkg::OFFSET_W-1:0] free_off_ff, free_off_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [bha_pkg::OFFSET_W-1:0] rsp_off_ff, rsp_off_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;

   logic             rd_used;
   logic [IDX_W-1:0] rd_start;
   logic [CMP_W-1:0] start_bytes;
   logic             free_match;
   logic [RB_W-1:0]  runb_sum;
   logic             run_fits;
   logic [IDX_W-1:0] run_first;
   logic [CMP_W-1:0] first_bytes;

   bha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_used     = rd_data[IDX_W];
   assign rd_start    = rd_data[IDX_W-1:0];
   assign start_bytes = CMP_W'(rd_start) * CMP_W'(BLOCK_BYTES);
   assign free_match  = rd_used && (start_bytes == CMP_W'(free_off_ff));
   assign runb_sum    = runb_ff + RB_W'(BLOCK_BYTES);
   assign run_fits    = runb_sum >= RB_W'(bytes_ff);
   assign run_first   = pend_addr_ff - run_ff;
   assign first_bytes = CMP_W'(first_ff) * CMP_W'(BLOCK_BYTES);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      run_in       = run_ff;
      runb_in      = runb_ff;
      first_in     = first_ff;
      mark_end_in  = mark_end_ff;
      bytes_in     = bytes_ff;
      free_off_in  = free_off_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_off_in   = '0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;

      // sequential read issue for the scan states
      if ((state_ff == ST_FREE) || (state_ff == ST_ALLOC)) begin
         if (issue_ff) begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = addr_ff;
            if (addr_ff == LAST) begin
               issue_in = 1'b0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end else begin
            pend_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               bytes_in    = req_alloc_bytes;
               free_off_in = req_free_offset;
               addr_in     = '0;
               issue_in    = 1'b1;
               pend_in     = 1'b0;
               run_in      = '0;
               runb_in     = '0;
               if (req_type == bha_pkg::REQ_FREE) begin
                  if (req_free_is_null) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_FREE;
                  end
               end else begin
                  if (req_alloc_bytes == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_ALLOC;
                  end
               end
            end
         end
         ST_FREE: begin
            if (pend_ff) begin
               if (free_match) begin
                  wr_en   = 1'b1;
                  wr_addr = pend_addr_ff;
               end
               if (pend_addr_ff == LAST) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_ALLOC: begin
            if (pend_ff) begin
               if (rd_used) begin
                  run_in  = '0;
                  runb_in = '0;
                  if (pend_addr_ff == LAST) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end else if (run_fits) begin
                  state_in    = ST_MARK;
                  addr_in     = run_first;
                  first_in    = run_first;
                  mark_end_in = pend_addr_ff;
                  issue_in    = 1'b0;
                  pend_in     = 1'b0;
               end else begin
                  run_in  = run_ff + 1'b1;
                  runb_in = runb_sum;
                  if (pend_addr_ff == LAST) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, first_ff};
            if (addr_ff == mark_end_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_off_in   = first_bytes[bha_pkg::OFFSET_W-1:0];
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_addr_ff <= pend_addr_in;
      run_ff       <= run_in;
      runb_ff      <= runb_in;
      first_ff     <= first_in;
      mark_end_ff  <= mark_end_in;
      bytes_ff     <= bytes_in;
      free_off_ff  <= free_off_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alloc_ok     = rsp_valid_ff & rsp_ok_ff;
   assign rsp_alloc_offset = rsp_valid_ff ? rsp_off_ff : '0;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("response without a request in progress");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (addr_ff <= mark_end_ff) && (first_ff <= addr_ff))
      else $error("mark write outside the found run");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while a request is still in progress");

   a_no_ram_use_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en && !rd_en)
      else $error("ram access while idle");

endmodule

// ----- dv/block_heap_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_heap_allocator_core_tb
// self-checking bench for the first-fit block heap allocator. a shadow heap
// predicts the grant of every accepted request. directed requests cover the
// size limits, the free corner cases and a full heap. weighted random
// alloc/free traffic then runs under three sender idle settings.
// ----------------------------------------------------------------------------
module block_heap_allocator_core_tb;
   import bha_pkg::*;

   localparam int NUM_BLOCKS    = NUM_BLOCKS_DEFAULT;
   localparam int BLOCK_BYTES   = BLOCK_BYTES_DEFAULT;
   localparam int HEAP_BYTES    = NUM_BLOCKS * BLOCK_BYTES;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * NUM_BLOCKS + 40;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_ITEMS   = 650;

   typedef struct packed {
      logic                ok;
      logic [OFFSET_W-1:0] offset;
   } grant_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [BYTES_W-1:0]  req_alloc_bytes;
   logic [OFFSET_W-1:0] req_free_offset;
   logic                req_free_is_null;
   logic                rsp_valid;
   logic                rsp_alloc_ok;
   logic [OFFSET_W-1:0] rsp_alloc_offset;

   bit        heap_used [NUM_BLOCKS];
   int        heap_owner[NUM_BLOCKS];
   grant_type pending_grants[$];
   int        mismatches   = 0;
   int        quiet_cycles = 0;
   int        send_idle_pct = 0;

   block_heap_allocator_core #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_alloc_bytes  (req_alloc_bytes),
      .req_free_offset  (req_free_offset),
      .req_free_is_null (req_free_is_null),
      .rsp_valid        (rsp_valid),
      .rsp_alloc_ok     (rsp_alloc_ok),
      .rsp_alloc_offset (rsp_alloc_offset)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow heap: first fit on alloc, release by owner start on free
   function automatic grant_type compute_grant(req_code_type kind, logic [BYTES_W-1:0] bytes,
                                               logic [OFFSET_W-1:0] off, logic is_null);
      grant_type g;
      int        need;
      int        run;
      int        first;
      g = '0;
      if (kind == REQ_ALLOC) begin
         need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
         if (bytes != 0 && need <= NUM_BLOCKS) begin
            run = 0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
               if (!g.ok) begin
                  if (heap_used[i]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run >= need) begin
                        first = i + 1 - need;
                        for (int j = first; j <= i; j++) begin
                           heap_used[j]  = 1'b1;
                           heap_owner[j] = first;
                        end
                        g.ok     = 1'b1;
                        g.offset = OFFSET_W'(first * BLOCK_BYTES);
                     end
                  end
               end
            end
         end
      end else if (!is_null) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (heap_used[i] && heap_owner[i] * BLOCK_BYTES == int'(off)) begin
               heap_used[i]  = 1'b0;
               heap_owner[i] = 0;
            end
         end
      end
      return g;
   endfunction

   function automatic int used_blocks();
      int n;
      n = 0;
      for (int i = 0; i < NUM_BLOCKS; i++) n += heap_used[i];
      return n;
   endfunction

   // byte offset of the run owning a random used block
   function automatic logic [OFFSET_W-1:0] live_offset();
      int n;
      int k;
      logic [OFFSET_W-1:0] off;
      n   = used_blocks();
      off = OFFSET_W'($urandom);
      if (n != 0) begin
         k = $urandom_range(n - 1);
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (heap_used[i]) begin
               if (k == 0) off = OFFSET_W'(heap_owner[i] * BLOCK_BYTES);
               k--;
            end
         end
      end
      return off;
   endfunction

   // leaves start high on return; release_requests drops it, the next send only in its idle cycles
   task automatic send_request(req_code_type kind, logic [BYTES_W-1:0] bytes,
                               logic [OFFSET_W-1:0] off, logic is_null);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_type         <= kind;
      req_alloc_bytes  <= bytes;
      req_free_offset  <= off;
      req_free_is_null <= is_null;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      pending_grants.push_back(compute_grant(kind, bytes, off, is_null));
   endtask

   task automatic release_requests();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_all_granted();
      release_requests();
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic test_alloc_sizes();
      send_request(REQ_ALLOC, 16'd0, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'd1, 10'h3ff, 1'b1);
      send_request(REQ_ALLOC, 16'd8, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'd9, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'hffff, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'(HEAP_BYTES + 1), 10'd0, 1'b0);
   endtask

   task automatic test_free_cases();
      // null free of a live run, misaligned free, hole reuse, then frees that empty the heap
      send_request(REQ_FREE, 16'hffff, 10'd0, 1'b1);
      send_request(REQ_FREE, 16'd0, 10'd3, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd8, 1'b0);
      send_request(REQ_ALLOC, 16'd8, 10'd0, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'h3ff, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd0, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd8, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd16, 1'b0);
   endtask

   task automatic test_full_heap();
      send_request(REQ_ALLOC, 16'(HEAP_BYTES), 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'd1, 10'd0, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'(HEAP_BYTES - BLOCK_BYTES), 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'(BLOCK_BYTES), 10'd0, 1'b0);
      send_request(REQ_ALLOC, 16'(BLOCK_BYTES), 10'd0, 1'b0);
      send_request(REQ_FREE, 16'd0, 10'(HEAP_BYTES - BLOCK_BYTES), 1'b0);
      send_request(REQ_FREE, 16'd0, 10'd0, 1'b0);
   endtask

   task automatic test_random_traffic(int idle_pct, int count);
      int                  pick;
      logic [BYTES_W-1:0]  bytes;
      logic [OFFSET_W-1:0] off;
      send_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         pick  = $urandom_range(99);
         bytes = BYTES_W'($urandom);
         off   = OFFSET_W'($urandom);
         // keep the heap from sitting full
         if (pick < 57 && used_blocks() > 96) pick += 43;
         if (pick < 45) begin
            send_request(REQ_ALLOC, BYTES_W'($urandom_range(96, 1)), off,
                         1'($urandom_range(1)));
         end else if (pick < 52) begin
            send_request(REQ_ALLOC, BYTES_W'($urandom_range(HEAP_BYTES + 80, 97)), off,
                         1'($urandom_range(1)));
         end else if (pick < 55) begin
            send_request(REQ_ALLOC, bytes, off, 1'($urandom_range(1)));
         end else if (pick < 57) begin
            send_request(REQ_ALLOC, '0, off, 1'($urandom_range(1)));
         end else if (pick < 89) begin
            send_request(REQ_FREE, bytes, live_offset(), 1'b0);
         end else if (pick < 94) begin
            send_request(REQ_FREE, bytes, off, 1'b0);
         end else if (pick < 97) begin
            send_request(REQ_FREE, bytes, OFFSET_W'(BLOCK_BYTES * $urandom_range(NUM_BLOCKS - 1)),
                         1'b0);
         end else begin
            send_request(REQ_FREE, bytes, live_offset(), 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      grant_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: ok=%0d offset=%0d", rsp_alloc_ok, rsp_alloc_offset);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_alloc_ok !== want.ok || rsp_alloc_offset !== want.offset) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch at %0t: ok exp %0d got %0d, offset exp %0d got %0d",
                           $realtime, want.ok, rsp_alloc_ok, want.offset, rsp_alloc_offset);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_ALLOC;
      req_alloc_bytes  = '0;
      req_free_offset  = '0;
      req_free_is_null = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      test_alloc_sizes();
      test_free_cases();
      test_full_heap();
      test_random_traffic(35, PHASE_ITEMS);
      wait_all_granted();
      test_random_traffic(46, PHASE_ITEMS);
      wait_all_granted();
      test_random_traffic(0, PHASE_ITEMS);
      wait_all_granted();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
